// ----- rtl/core/grid_shortest_path_router_macros.svh -----
// Assertion helpers for the grid router core.
// Each expects clk and rst_n in scope; checks are off while reset is low.
`ifndef GRID_SHORTEST_PATH_ROUTER_MACROS_SVH
`define GRID_SHORTEST_PATH_ROUTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define GSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GSP_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/gsp_pkg.sv -----
`default_nettype none

package gsp_pkg;

  localparam int CELL_W    = 5;
  localparam int STEP_W    = 4;
  localparam int MASK_W    = 20;
  localparam int ROW_CNT_W = 3;
  localparam int DIST_W    = 5;

  localparam logic [ROW_CNT_W-1:0] ROW_CNT_RESET = 3'd5;

  localparam int COLUMNS_DEF     = 4;
  localparam int MAX_ROWS_DEF    = 5;
  localparam int DEPTH_LIMIT_DEF = 12;

  typedef logic [DIST_W-1:0] dist_t;

  // Shared control broadcast to every grid cell.
  typedef struct packed {
    logic  load;
    logic  expand;
    dist_t level;
    dist_t target;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/gsp_query_if.sv -----
`default_nettype none

interface gsp_query_if import gsp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] start_cell;
  logic [CELL_W-1:0] goal_cell;
  logic [MASK_W-1:0] occupied_mask;

  modport source (output valid, start_cell, goal_cell, occupied_mask, input ready);
  modport sink   (input valid, start_cell, goal_cell, occupied_mask, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gsp_route_if.sv -----
`default_nettype none

interface gsp_route_if import gsp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] route_cell;
  logic [STEP_W-1:0] step_index;
  logic              found;
  logic              last;

  modport source (output valid, route_cell, step_index, found, last, input ready);
  modport sink   (input valid, route_cell, step_index, found, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gsp_cell.sv -----
`default_nettype none

// One grid cell: reached flag plus distance from the goal.
module gsp_cell import gsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       seed,
  input  logic       passable,
  input  logic       active,
  input  logic       nbr_reached,
  output logic       reached,
  output logic       match
);

  logic  reached_r, reached_nxt;
  dist_t dist_r, dist_nxt;

  always_comb begin
    reached_nxt = reached_r;
    dist_nxt    = dist_r;
    if (ctrl.load) begin
      reached_nxt = seed;
      dist_nxt    = '0;
    end else if (ctrl.expand && !reached_r && active && passable && nbr_reached) begin
      reached_nxt = 1'b1;
      dist_nxt    = ctrl.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= 1'b0;
    end else begin
      reached_r <= reached_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  assign reached = reached_r;
  assign match   = reached_r && (dist_r == ctrl.target);

endmodule

`default_nettype wire

// ----- rtl/core/grid_shortest_path_router.sv -----
// Channel   Dir  Protocol       Word
// in_chan   in   valid/ready    start_cell, goal_cell, occupied_mask
// out_chan  out  valid/ready    route_cell, step_index, found, last
// cfg_*     in   write enable   row_count (3 bits), no read-back
//
// One query at a time. After accept the wavefront grows from the goal, and
// a route of d moves leaves as d+1 words, one word per cycle unless the
// output stalls. A query with no route yields a single not-found word.
// Reset (rst_n, synchronous) sets row_count to 5 and idles the engine.
// A stalled output holds the walk; the next query is taken while the last
// word of the previous one still waits in the output register.
`default_nettype none

`include "grid_shortest_path_router_macros.svh"

module grid_shortest_path_router import gsp_pkg::*; #(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gsp_query_if.sink            in_chan,
  gsp_route_if.source          out_chan,
  input  logic                 cfg_we,
  input  logic [ROW_CNT_W-1:0] cfg_wdata
);

  localparam int    NCELLS     = COLUMNS * MAX_ROWS;
  localparam dist_t LAST_LEVEL = dist_t'(DEPTH_LIMIT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXPAND,
    S_WALK,
    S_MISS
  } state_t;

  // Control and query registers.
  state_t                state_r, state_nxt;
  logic [ROW_CNT_W-1:0]  row_count_r;
  dist_t                 level_r, level_nxt;
  logic                  final_r, final_nxt;
  logic [NCELLS-1:0]     start_oh_r, start_oh_nxt;
  logic [NCELLS-1:0]     pass_r, pass_nxt;
  logic [NCELLS-1:0]     cur_oh_r, cur_oh_nxt;
  dist_t                 here_r, here_nxt;
  dist_t                 step_r, step_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]     out_route_r, out_route_nxt;
  logic [STEP_W-1:0]     out_step_r, out_step_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_last_r, out_last_nxt;

  // Grid-wide vectors.
  logic [NCELLS-1:0]     start_oh_in, goal_oh_in, occ_in;
  logic [NCELLS-1:0]     active, nbr_any, reached, match;
  logic [NCELLS-1:0]     cand_up, cand_left, cand_down, cand_right, next_oh;
  cell_ctrl_t            cell_ctrl;

  logic [3:0]            rows_eff;
  logic [7:0]            cells_lim;
  logic                  in_range;
  logic                  accept;
  logic                  slot_free;
  logic                  start_reached;
  logic [31:0]           cur_idx;
  logic [31:0]           step_ext;

  // Clamp the configured rows and size the live grid.
  assign rows_eff  = (4'(row_count_r) > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : 4'(row_count_r);
  assign cells_lim = 8'(rows_eff) * 8'(COLUMNS);
  assign in_range  = (8'(in_chan.start_cell) < cells_lim) &&
                     (8'(in_chan.goal_cell) < cells_lim);

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;
  assign start_reached = |(start_oh_r & reached);

  // Cell array: each cell looks at its four neighbors' reached flags during
  // expansion and at the walk cursor during route read-out.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    localparam int ROW = i / COLUMNS;
    localparam int COL = i % COLUMNS;
    logic [3:0] nb;

    assign start_oh_in[i] = (32'(in_chan.start_cell) == i);
    assign goal_oh_in[i]  = (32'(in_chan.goal_cell) == i);
    assign active[i]      = (32'(rows_eff) > ROW);

    if (i < MASK_W) begin : g_occ
      assign occ_in[i] = in_chan.occupied_mask[i];
    end else begin : g_free
      assign occ_in[i] = 1'b0;
    end

    // Up neighbor, and the cursor just above picking this cell as "down".
    if (ROW > 0) begin : g_has_up
      assign nb[0]        = reached[i-COLUMNS];
      assign cand_down[i] = match[i] && cur_oh_r[i-COLUMNS];
    end else begin : g_no_up
      assign nb[0]        = 1'b0;
      assign cand_down[i] = 1'b0;
    end

    if (COL > 0) begin : g_has_left
      assign nb[1]         = reached[i-1];
      assign cand_right[i] = match[i] && cur_oh_r[i-1];
    end else begin : g_no_left
      assign nb[1]         = 1'b0;
      assign cand_right[i] = 1'b0;
    end

    if (ROW < MAX_ROWS - 1) begin : g_has_down
      assign nb[2]      = reached[i+COLUMNS];
      assign cand_up[i] = match[i] && cur_oh_r[i+COLUMNS];
    end else begin : g_no_down
      assign nb[2]      = 1'b0;
      assign cand_up[i] = 1'b0;
    end

    if (COL < COLUMNS - 1) begin : g_has_right
      assign nb[3]        = reached[i+1];
      assign cand_left[i] = match[i] && cur_oh_r[i+1];
    end else begin : g_no_right
      assign nb[3]        = 1'b0;
      assign cand_left[i] = 1'b0;
    end

    assign nbr_any[i] = |nb;

    gsp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .seed        (goal_oh_in[i]),
      .passable    (pass_r[i]),
      .active      (active[i]),
      .nbr_reached (nbr_any[i]),
      .reached     (reached[i]),
      .match       (match[i])
    );
  end

  // Next cursor: first direction with a one-step-closer cell, in the order
  // up, left, down, right.
  always_comb begin
    if (|cand_up) begin
      next_oh = cand_up;
    end else if (|cand_left) begin
      next_oh = cand_left;
    end else if (|cand_down) begin
      next_oh = cand_down;
    end else begin
      next_oh = cand_right;
    end
  end

  // Turn the one-hot cursor into a cell number.
  always_comb begin
    cur_idx = '0;
    for (int i = 0; i < NCELLS; i++) begin
      if (cur_oh_r[i]) begin
        cur_idx = cur_idx | 32'(i);
      end
    end
  end

  assign step_ext = 32'(step_r);

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    final_nxt     = final_r;
    start_oh_nxt  = start_oh_r;
    pass_nxt      = pass_r;
    cur_oh_nxt    = cur_oh_r;
    here_nxt      = here_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_route_nxt = out_route_r;
    out_step_nxt  = out_step_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;

    cell_ctrl        = '0;
    cell_ctrl.level  = level_r;
    cell_ctrl.target = here_r - dist_t'(1);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Seed the goal and latch the passable map; the start is always
          // passable even when its own mask bit is set.
          cell_ctrl.load = 1'b1;
          start_oh_nxt   = start_oh_in;
          pass_nxt       = start_oh_in | ~occ_in;
          level_nxt      = dist_t'(1);
          final_nxt      = 1'b0;
          state_nxt      = in_range ? S_EXPAND : S_MISS;
        end
      end
      S_EXPAND: begin
        if (start_reached) begin
          // Start was reached at the previous level.
          cur_oh_nxt = start_oh_r;
          here_nxt   = level_r - dist_t'(1);
          step_nxt   = '0;
          state_nxt  = S_WALK;
        end else if (final_r) begin
          state_nxt = S_MISS;
        end else begin
          cell_ctrl.expand = 1'b1;
          final_nxt        = (level_r == LAST_LEVEL);
          level_nxt        = level_r + dist_t'(1);
        end
      end
      S_WALK: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_route_nxt = cur_idx[CELL_W-1:0];
          out_step_nxt  = step_ext[STEP_W-1:0];
          out_found_nxt = 1'b1;
          out_last_nxt  = (here_r == '0);
          if (here_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cur_oh_nxt = next_oh;
            here_nxt   = here_r - dist_t'(1);
            step_nxt   = step_r + dist_t'(1);
          end
        end
      end
      S_MISS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_route_nxt = '0;
          out_step_nxt  = '0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_CNT_RESET;
    end else if (cfg_we) begin
      row_count_r <= cfg_wdata;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    level_r     <= level_nxt;
    start_oh_r  <= start_oh_nxt;
    pass_r      <= pass_nxt;
    cur_oh_r    <= cur_oh_nxt;
    here_r      <= here_nxt;
    step_r      <= step_nxt;
    out_route_r <= out_route_nxt;
    out_step_r  <= out_step_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.route_cell = out_route_r;
  assign out_chan.step_index = out_step_r;
  assign out_chan.found      = out_found_r;
  assign out_chan.last       = out_last_r;

  // Cursor stays on exactly one cell through the walk.
  `GSP_ASSERT_IMPLY(a_walk_onehot, state_r == S_WALK, $onehot(cur_oh_r),
    "walk cursor is not one-hot")
  // A closer neighbor always exists until the goal is reached.
  `GSP_ASSERT_IMPLY(a_walk_next, (state_r == S_WALK) && slot_free && (here_r != '0),
    next_oh != '0, "walk found no closer neighbor")
  // A not-found word is a single final word on cell zero.
  `GSP_ASSERT_IMPLY(a_miss_word, out_chan.valid && !out_chan.found,
    out_chan.last && (out_chan.route_cell == '0), "malformed not-found word")
  // A stalled walk holds its cursor.
  `GSP_ASSERT_NEXT(a_walk_hold, (state_r == S_WALK) && !slot_free,
    $stable(cur_oh_r), "walk advanced while output stalled")

endmodule

`default_nettype wire

// ----- sim/tb_grid_shortest_path_router.sv -----
`timescale 1ns / 100ps

module tb_grid_shortest_path_router;
  import gsp_pkg::*;

  localparam int GRID_COLS    = COLUMNS_DEF;
  localparam int GRID_ROWS    = MAX_ROWS_DEF;
  localparam int DEPTH_LIMIT  = DEPTH_LIMIT_DEF;
  localparam int GRID_CELLS   = GRID_COLS * GRID_ROWS;
  localparam int UNREACHED    = 255;
  localparam int LONG_HOLD    = 200;   // cycles the route side holds off once
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 40;    // covers the longest query after the last word
  localparam int PHASE_WORDS  = 20;
  localparam int N_DIRECTED   = 21;
  localparam int N_PHASES     = 10;
  localparam int HOLD_PHASE   = 1;
  localparam int MAX_REPORTS  = 100;

  // Move order of the search; ties between shortest routes go to the lowest.
  typedef enum logic [1:0] {DIR_UP, DIR_LEFT, DIR_DOWN, DIR_RIGHT} heading_t;

  typedef struct packed {
    logic [CELL_W-1:0] route_cell;
    logic [STEP_W-1:0] step_index;
    logic              found;
    logic              last;
  } route_word_t;

  // One directed query; preset rows carry their single answer inline.
  typedef struct packed {
    logic [CELL_W-1:0] start_cell;
    logic [CELL_W-1:0] goal_cell;
    logic [MASK_W-1:0] occupied_mask;
    logic              preset;
    logic [CELL_W-1:0] preset_cell;
    logic              preset_found;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [ROW_CNT_W-1:0] cfg_wdata;

  gsp_query_if query_chan ();
  gsp_route_if route_chan ();

  grid_shortest_path_router uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (query_chan),
    .out_chan  (route_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Route words still owed by the block, oldest first.
  route_word_t          expected_route [$];
  route_word_t          head_word;
  logic [ROW_CNT_W-1:0] rows_shadow;
  int                   fail_count = 0;
  bit                   calm = 1'b0;   // set for the last phase: no idling on either side
  int                   hold_req = 0;  // bumped by stimulus to request one long hold-off
  int                   hold_ack = 0;  // caught up by the route side when the hold is done

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Neighbor of cell c in direction dir, or -1 when that leaves the grid.
  function automatic int step_cell(input int c, input heading_t dir, input int rows);
    int r;
    int col;
    r   = c / GRID_COLS;
    col = c % GRID_COLS;
    case (dir)
      DIR_UP:   return (r > 0) ? c - GRID_COLS : -1;
      DIR_LEFT: return (col > 0) ? c - 1 : -1;
      DIR_DOWN: return (r + 1 < rows) ? c + GRID_COLS : -1;
      default:  return (col + 1 < GRID_COLS) ? c + 1 : -1;
    endcase
  endfunction

  // Work out the route words for one query and append them to expected_route.
  // Flood distances out from the goal, then walk downhill from the start,
  // taking the first direction in search order that drops by one.
  function automatic void plan_route(input logic [CELL_W-1:0] start,
                                     input logic [CELL_W-1:0] goal,
                                     input logic [MASK_W-1:0] mask,
                                     input logic [ROW_CNT_W-1:0] rows_cfg);
    int          dist_map [GRID_CELLS];
    int          rows;
    int          cells;
    int          cur;
    int          here;
    int          nb;
    int          steps;
    bit          reachable;
    bit          moved;
    route_word_t w;
    rows      = (rows_cfg > GRID_ROWS) ? GRID_ROWS : rows_cfg;
    cells     = rows * GRID_COLS;
    reachable = 1'b0;
    if (start < cells && goal < cells) begin
      foreach (dist_map[i]) dist_map[i] = UNREACHED;
      dist_map[goal] = 0;
      // Grow one ring per level; the start may be entered even if occupied,
      // the goal is seeded directly so its own mask bit never matters.
      for (int k = 0; k + 1 < DEPTH_LIMIT; k++)
        for (int c = 0; c < cells; c++)
          if (dist_map[c] == k)
            for (int d = 0; d < 4; d++) begin
              nb = step_cell(c, heading_t'(d), rows);
              if (nb >= 0 && dist_map[nb] == UNREACHED && (nb == start || !mask[nb]))
                dist_map[nb] = k + 1;
            end
      reachable = dist_map[start] < DEPTH_LIMIT;
    end
    if (!reachable) begin
      w = '{route_cell: '0, step_index: '0, found: 1'b0, last: 1'b1};
      expected_route.push_back(w);
      return;
    end
    cur   = start;
    steps = 0;
    do begin
      here         = dist_map[cur];
      w.route_cell = CELL_W'(cur);
      w.step_index = STEP_W'(steps);
      w.found      = 1'b1;
      w.last       = (here == 0);
      expected_route.push_back(w);
      steps++;
      moved = 1'b0;
      for (int d = 0; d < 4; d++) begin
        nb = step_cell(cur, heading_t'(d), rows);
        if (!moved && here != 0 && nb >= 0 && dist_map[nb] + 1 == here) begin
          cur   = nb;
          moved = 1'b1;
        end
      end
    end while (here != 0 && steps < DEPTH_LIMIT);
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_REPORTS)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Offer one query word and hold it until the block takes it; record what it owes.
  task automatic offer_query(input logic [CELL_W-1:0] start, input logic [CELL_W-1:0] goal,
                             input logic [MASK_W-1:0] mask, input bit use_preset,
                             input route_word_t preset_word);
    @(negedge clk);
    query_chan.valid         = 1'b1;
    query_chan.start_cell    = start;
    query_chan.goal_cell     = goal;
    query_chan.occupied_mask = mask;
    do @(posedge clk); while (query_chan.ready !== 1'b1);
    if (use_preset)
      expected_route.push_back(preset_word);
    else
      plan_route(start, goal, mask, rows_shadow);
  endtask

  // Drop valid for a burst of cycles.
  task automatic pause_query(input int cycles);
    @(negedge clk);
    query_chan.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_routes();
    while (expected_route.size() != 0) @(posedge clk);
  endtask

  // Stop offering, let every owed word come out, then write row_count.
  task automatic set_rows(input logic [ROW_CNT_W-1:0] value);
    pause_query(1);
    wait_for_routes();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we      = 1'b0;
    rows_shadow = value;
  endtask

  // Route side: alternate random stall bursts (none when calm) with ready
  // stretches; serve a long hold-off whenever stimulus asks for one.
  initial begin : route_sink
    route_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ack != hold_req) begin
        route_chan.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_ack = hold_req;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        route_chan.ready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        route_chan.ready = 1'b1;
        repeat ($urandom_range(0, 29)) @(negedge clk);
      end
    end
  end

  // Check every accepted route word against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && route_chan.valid === 1'b1 && route_chan.ready === 1'b1) begin
      if (expected_route.size() == 0) begin
        report_mismatch("unexpected word, route_cell", route_chan.route_cell, -1);
      end else begin
        head_word = expected_route.pop_front();
        if (route_chan.route_cell !== head_word.route_cell)
          report_mismatch("route_cell", route_chan.route_cell, head_word.route_cell);
        if (route_chan.step_index !== head_word.step_index)
          report_mismatch("step_index", route_chan.step_index, head_word.step_index);
        if (route_chan.found !== head_word.found)
          report_mismatch("found", route_chan.found, head_word.found);
        if (route_chan.last !== head_word.last)
          report_mismatch("last", route_chan.last, head_word.last);
      end
    end
  end

  // Give up when neither channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((query_chan.valid === 1'b1 && query_chan.ready === 1'b1) ||
          (route_chan.valid === 1'b1 && route_chan.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    directed_row_t        directed_rows [N_DIRECTED];
    logic [ROW_CNT_W-1:0] phase_rows [N_PHASES];
    route_word_t          preset_word;
    int                   cells;
    logic [CELL_W-1:0]    start;
    logic [CELL_W-1:0]    goal;
    logic [MASK_W-1:0]    mask;

    // Hold every input at a known value through reset.
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_wdata                = '0;
    query_chan.valid         = 1'b0;
    query_chan.start_cell    = '0;
    query_chan.goal_cell     = '0;
    query_chan.occupied_mask = '0;
    rows_shadow              = ROW_CNT_RESET;

    // start, goal, mask, preset, preset cell, preset found
    directed_rows = '{
      '{5'd0,  5'd0,  20'h00000, 1'b1, 5'd0,  1'b1},  // start is the goal
      '{5'd19, 5'd19, 20'hFFFFF, 1'b1, 5'd19, 1'b1},  // same, every cell occupied
      '{5'd20, 5'd0,  20'h00000, 1'b1, 5'd0,  1'b0},  // start just off the grid
      '{5'd0,  5'd31, 20'h00000, 1'b1, 5'd0,  1'b0},  // goal at the top code
      '{5'd31, 5'd31, 20'hFFFFF, 1'b1, 5'd0,  1'b0},  // both off the grid
      '{5'd0,  5'd19, 20'hFFFFE, 1'b1, 5'd0,  1'b0},  // start boxed in, no route
      '{5'd0,  5'd19, 20'h00000, 1'b0, 5'd0,  1'b0},  // corner to corner
      '{5'd19, 5'd0,  20'h00000, 1'b0, 5'd0,  1'b0},
      '{5'd0,  5'd3,  20'h00000, 1'b0, 5'd0,  1'b0},  // straight right
      '{5'd3,  5'd0,  20'h00000, 1'b0, 5'd0,  1'b0},  // straight left
      '{5'd16, 5'd0,  20'h00000, 1'b0, 5'd0,  1'b0},  // straight up
      '{5'd0,  5'd16, 20'h00000, 1'b0, 5'd0,  1'b0},  // straight down
      '{5'd0,  5'd1,  20'h00002, 1'b0, 5'd0,  1'b0},  // occupied goal is still entered
      '{5'd5,  5'd6,  20'h00020, 1'b0, 5'd0,  1'b0},  // occupied start is left freely
      '{5'd0,  5'd17, 20'h0E070, 1'b0, 5'd0,  1'b0},  // snake of the longest legal route
      '{5'd0,  5'd18, 20'h0E070, 1'b0, 5'd0,  1'b0},  // one move beyond the limit
      '{5'd0,  5'd1,  20'hFFFFF, 1'b0, 5'd0,  1'b0},  // full mask, adjacent goal
      '{5'd5,  5'd10, 20'h00000, 1'b0, 5'd0,  1'b0},  // tie broken by move order
      '{5'd10, 5'd5,  20'h00000, 1'b0, 5'd0,  1'b0},
      '{5'd12, 5'd3,  20'h00000, 1'b0, 5'd0,  1'b0},
      '{5'd7,  5'd4,  20'h00066, 1'b0, 5'd0,  1'b0}   // detour around a block
    };
    // Row counts per random phase: both legal extremes, zero and the
    // out-of-range values, ending on the full map with no idling.
    phase_rows = '{3'd2, 3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd5};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words run on the reset row count.
    foreach (directed_rows[i]) begin
      preset_word = '{route_cell: directed_rows[i].preset_cell, step_index: '0,
                      found: directed_rows[i].preset_found, last: 1'b1};
      if ($urandom_range(0, 3) == 0) pause_query($urandom_range(1, 12));
      offer_query(directed_rows[i].start_cell, directed_rows[i].goal_cell,
                  directed_rows[i].occupied_mask, directed_rows[i].preset, preset_word);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_rows(phase_rows[p]);
      calm = (p == N_PHASES - 1);
      // Stall the route side for a long stretch and keep offering so the
      // block backs up and stalls its input.
      if (p == HOLD_PHASE) hold_req = hold_req + 1;
      cells = ((phase_rows[p] > GRID_ROWS) ? GRID_ROWS : phase_rows[p]) * GRID_COLS;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Mostly in-grid cells; some noise over the whole field.
        if (cells == 0 || $urandom_range(0, 6) == 0)
          start = CELL_W'($urandom_range(0, 31));
        else
          start = CELL_W'($urandom_range(0, cells - 1));
        if (cells == 0 || $urandom_range(0, 6) == 0)
          goal = CELL_W'($urandom_range(0, 31));
        else if ($urandom_range(0, 19) == 0)
          goal = start;
        else
          goal = CELL_W'($urandom_range(0, cells - 1));
        // Vary density so that routes, detours and dead ends all show up.
        case ($urandom_range(0, 3))
          0:       mask = MASK_W'($urandom & $urandom & $urandom);
          1:       mask = MASK_W'($urandom & $urandom);
          2:       mask = MASK_W'($urandom);
          default: mask = MASK_W'($urandom | $urandom);
        endcase
        if (!calm && p != HOLD_PHASE && $urandom_range(0, 3) == 0)
          pause_query($urandom_range(1, 12));
        offer_query(start, goal, mask, 1'b0, preset_word);
      end
    end

    pause_query(1);
    wait_for_routes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
